@@ src/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the list block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never hold outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

@@ src/ial_pkg.sv @@
// ---------------------------------------------------------------------------
// ial_pkg
// Types, codes and sizes shared by the indexed list block.
// ---------------------------------------------------------------------------
package ial_pkg;

   localparam int CAPACITY = 64;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_GET    = 2'd2,
      OP_FIND   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_RANGE   = 2'd1,
      ST_FULL    = 2'd2,
      ST_MISSING = 2'd3
   } status_type;

   typedef struct packed {
      opcode_type               opcode;
      logic [CNT_W-1:0]         position;
      logic signed [DATA_W-1:0] item_value;
   } cmd_type;

   typedef struct packed {
      logic                     done;
      status_type               status;
      logic signed [DATA_W-1:0] read_data;
      logic [ADDR_W-1:0]        match_position;
      logic [CNT_W-1:0]         item_count;
   } result_type;

endpackage

@@ src/ial_ram.sv @@
// ---------------------------------------------------------------------------
// ial_ram
// Generic one-write, one-read RAM with registered read data.
// ---------------------------------------------------------------------------
module ial_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/ial_engine.sv @@
// ---------------------------------------------------------------------------
// ial_engine
// Sequencer that walks the entry RAM one word a cycle for shift and search.
// ---------------------------------------------------------------------------
module ial_engine import ial_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  cmd_type                  cmd,
   input  logic                     rsp_free,
   output logic                     idle,
   output result_type               result,
   output logic                     ram_wr_en,
   output logic [ADDR_W-1:0]        ram_wr_addr,
   output logic [DATA_W-1:0]        ram_wr_data,
   output logic [ADDR_W-1:0]        ram_rd_addr,
   input  logic [DATA_W-1:0]        ram_rd_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SHIFT_UP,
      S_PLACE,
      S_SHIFT_DOWN,
      S_GET_WAIT,
      S_SCAN,
      S_FINISH
   } state_type;

   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);
   localparam logic [CNT_W-1:0] TWO     = CNT_W'(2);

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         pos_ff, pos_in;
   logic [CNT_W-1:0]         idx_ff, idx_in;
   logic signed [DATA_W-1:0] val_ff, val_in;
   status_type               status_ff, status_in;
   logic signed [DATA_W-1:0] rdata_ff, rdata_in;
   logic [ADDR_W-1:0]        mpos_ff, mpos_in;
   logic [CNT_W-1:0]         count_dec;
   logic [CNT_W-1:0]         idx_down;
   logic [CNT_W-1:0]         idx_skip;
   logic [CNT_W-1:0]         pos_next;
   logic                     hit;

   assign count_dec = count_ff - ONE;
   assign idx_down  = idx_ff - TWO;
   assign idx_skip  = idx_ff + TWO;
   assign pos_next  = cmd.position + ONE;
   // the data comparator, used only by the search walk
   assign hit       = (ram_rd_data == val_ff);

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      pos_in      = pos_ff;
      idx_in      = idx_ff;
      val_in      = val_ff;
      status_in   = status_ff;
      rdata_in    = rdata_ff;
      mpos_in     = mpos_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = idx_ff[ADDR_W-1:0];
      ram_wr_data = ram_rd_data;
      ram_rd_addr = '0;
      result.done           = 1'b0;
      result.status         = status_ff;
      result.read_data      = rdata_ff;
      result.match_position = mpos_ff;
      result.item_count     = count_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               pos_in    = cmd.position;
               val_in    = cmd.item_value;
               status_in = ST_OK;
               rdata_in  = '0;
               mpos_in   = '0;
               state_in  = S_FINISH;
               case (cmd.opcode)
                  OP_INSERT: begin
                     if (cmd.position > count_ff) begin
                        status_in = ST_RANGE;
                     end else if (count_ff == CAP_CNT) begin
                        status_in = ST_FULL;
                     end else if (cmd.position == count_ff) begin
                        // append: nothing to shift
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = cmd.position[ADDR_W-1:0];
                        ram_wr_data = cmd.item_value;
                        count_in    = count_ff + ONE;
                     end else begin
                        ram_rd_addr = count_dec[ADDR_W-1:0];
                        idx_in      = count_ff;
                        state_in    = S_SHIFT_UP;
                     end
                  end
                  OP_REMOVE: begin
                     if (cmd.position >= count_ff) begin
                        status_in = ST_RANGE;
                     end else if (pos_next == count_ff) begin
                        count_in = count_dec;
                     end else begin
                        ram_rd_addr = pos_next[ADDR_W-1:0];
                        idx_in      = cmd.position;
                        state_in    = S_SHIFT_DOWN;
                     end
                  end
                  OP_GET: begin
                     if (cmd.position >= count_ff) begin
                        status_in = ST_RANGE;
                     end else begin
                        ram_rd_addr = cmd.position[ADDR_W-1:0];
                        state_in    = S_GET_WAIT;
                     end
                  end
                  OP_FIND: begin
                     if (count_ff == '0) begin
                        status_in = ST_MISSING;
                     end else begin
                        ram_rd_addr = '0;
                        idx_in      = '0;
                        state_in    = S_SCAN;
                     end
                  end
                  default: begin
                     status_in = ST_OK;
                  end
               endcase
            end
         end
         S_SHIFT_UP: begin
            // move word idx-1 to idx, fetch the next one down
            ram_wr_en = 1'b1;
            if (idx_ff == pos_ff + ONE) begin
               state_in = S_PLACE;
            end else begin
               ram_rd_addr = idx_down[ADDR_W-1:0];
               idx_in      = idx_ff - ONE;
            end
         end
         S_PLACE: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = pos_ff[ADDR_W-1:0];
            ram_wr_data = val_ff;
            count_in    = count_ff + ONE;
            state_in    = S_FINISH;
         end
         S_SHIFT_DOWN: begin
            // move word idx+1 to idx, fetch the next one up
            ram_wr_en = 1'b1;
            if (idx_skip == count_ff) begin
               count_in = count_dec;
               state_in = S_FINISH;
            end else begin
               ram_rd_addr = idx_skip[ADDR_W-1:0];
               idx_in      = idx_ff + ONE;
            end
         end
         S_GET_WAIT: begin
            rdata_in = ram_rd_data;
            state_in = S_FINISH;
         end
         S_SCAN: begin
            if (hit) begin
               mpos_in  = idx_ff[ADDR_W-1:0];
               state_in = S_FINISH;
            end else if (idx_ff + ONE == count_ff) begin
               status_in = ST_MISSING;
               state_in  = S_FINISH;
            end else begin
               ram_rd_addr = idx_ff[ADDR_W-1:0] + ADDR_W'(1);
               idx_in      = idx_ff + ONE;
            end
         end
         S_FINISH: begin
            // hold until the response register can take the transaction
            if (rsp_free) begin
               result.done = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      pos_ff    <= pos_in;
      idx_ff    <= idx_in;
      val_ff    <= val_in;
      status_ff <= status_in;
      rdata_ff  <= rdata_in;
      mpos_ff   <= mpos_in;
   end

   assign idle = (state_ff == S_IDLE);

endmodule

@@ src/indexed_array_list.sv @@
// ---------------------------------------------------------------------------
// indexed_array_list
// Fixed-capacity ordered list of signed words with insert, remove, get and
// find, built on one entry RAM walked by a small sequencer.
//
//   channel | direction | ports
//   --------+-----------+-------------------------------------------------
//   req     | in        | req_valid/ready, opcode, position, item_value
//   rsp     | out       | rsp_valid/ready, status, read_data,
//           |           | match_position, item_count
//
// Insert shifts the words from position on up and writes the item, remove
// shifts the words above position down, get reads one word, find scans
// until a match or the end. The RAM's single read port moves one word a
// cycle. req_ready is high only while the sequencer is idle; a finished
// result is held in the response register, and the next request is taken
// meanwhile. Synchronous reset empties the list; the RAM needs no clearing.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module indexed_array_list import ial_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_opcode,
   input  logic [CNT_W-1:0]         req_position,
   input  logic signed [DATA_W-1:0] req_item_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [1:0]               rsp_status,
   output logic signed [DATA_W-1:0] rsp_read_data,
   output logic [ADDR_W-1:0]        rsp_match_position,
   output logic [CNT_W-1:0]         rsp_item_count
);

   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   cmd_type             cmd;
   result_type          result;
   logic                req_fire;
   logic                eng_idle;
   logic                rsp_free;
   logic                ram_wr_en;
   logic [ADDR_W-1:0]   ram_wr_addr;
   logic [DATA_W-1:0]   ram_wr_data;
   logic [ADDR_W-1:0]   ram_rd_addr;
   logic [DATA_W-1:0]   ram_rd_data;

   logic                     rsp_valid_ff;
   status_type               rsp_status_ff;
   logic signed [DATA_W-1:0] rsp_read_data_ff;
   logic [ADDR_W-1:0]        rsp_match_ff;
   logic [CNT_W-1:0]         rsp_count_ff;

   assign cmd.opcode     = opcode_type'(req_opcode);
   assign cmd.position   = req_position;
   assign cmd.item_value = req_item_value;
   assign req_ready      = eng_idle;
   assign req_fire       = req_valid && req_ready;
   assign rsp_free       = !rsp_valid_ff || rsp_ready;

   ial_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   ial_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .start       (req_fire),
      .cmd         (cmd),
      .rsp_free    (rsp_free),
      .idle        (eng_idle),
      .result      (result),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (result.done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (result.done) begin
         rsp_status_ff    <= result.status;
         rsp_read_data_ff <= result.read_data;
         rsp_match_ff     <= result.match_position;
         rsp_count_ff     <= result.item_count;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_read_data      = rsp_read_data_ff;
   assign rsp_match_position = rsp_match_ff;
   assign rsp_item_count     = rsp_count_ff;

   `ASSERT_CLK(a_busy_on_accept, clock, reset, req_fire |=> !req_ready, "idle after accept")
   `ASSERT_NEVER(a_no_overwrite, clock, reset, result.done && !rsp_free, "response overwritten")
   `ASSERT_CLK(a_count_ok, clock, reset, rsp_valid |-> rsp_item_count <= CAP_CNT, "count too big")

endmodule
